// ===== rtl/pva_pkg.sv =====
// shared constants, types and saturating arithmetic for the polygon vertex analyzer
`default_nettype none

package pva_pkg;

    // coordinate width of the vertex and test point fields
    localparam int COORD_BITS = 24;
    // sums and differences of two coordinates
    localparam int OPD_W      = COORD_BITS + 1;
    // exact product of two operands
    localparam int PROD_W     = 2 * OPD_W;
    localparam int SUM_W      = 64;
    localparam int AREA_W     = SUM_W - 1;
    // working width for clamping a product to the sum range
    localparam int SAT_W      = (PROD_W > SUM_W + 1) ? PROD_W : SUM_W + 1;

    // edge queue between front and back, power of two deep
    localparam int Q_DEPTH    = 4;
    localparam int Q_AW       = $clog2(Q_DEPTH);

    // stream payload widths, rounded up to whole bytes
    localparam int IN_FIELD_W  = 2 * COORD_BITS;
    localparam int IN_DATA_W   = ((IN_FIELD_W + 7) / 8) * 8;
    localparam int OUT_FIELD_W = AREA_W + 2 + 4 * COORD_BITS;
    localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = COORD_BITS;
    localparam logic [CFG_IDX_W-1:0] REG_TEST_X = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TEST_Y = CFG_IDX_W'(1);

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [OPD_W-1:0]      opd_t;
    typedef logic signed [PROD_W-1:0]     prod_t;
    typedef logic signed [SUM_W-1:0]      sum_t;

    localparam sum_t SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam sum_t SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef struct packed {
        coord_t min_x;
        coord_t min_y;
        coord_t max_x;
        coord_t max_y;
    } box_t;

    // one accepted vertex: the incoming edge, the closing edge and polygon flags
    typedef struct packed {
        prod_t term1;   // shoelace term of edge prev -> cur
        prod_t term2;   // shoelace term of edge cur -> first
        prod_t lhs1;    // crossing products of edge prev -> cur
        prod_t rhs1;
        prod_t lhs2;    // crossing products of edge cur -> first
        prod_t rhs2;
        logic  cross1;  // edge straddles the test row
        logic  cross2;
        logic  dpos1;   // edge runs downward in y
        logic  dpos2;
        logic  first;   // first vertex of a polygon
        logic  last;    // closing vertex
        logic  full;    // at least three vertices seen
        box_t  box;
    } edge_item_t;

    // clamp an exact product to the signed 64-bit range
    function automatic sum_t sat_term(input prod_t p);
        logic signed [SAT_W-1:0] e;
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        e  = SAT_W'(p);
        hi = {{(SAT_W-SUM_W+1){1'b0}}, {(SUM_W-1){1'b1}}};
        lo = {{(SAT_W-SUM_W+1){1'b1}}, {(SUM_W-1){1'b0}}};
        if (e > hi) begin
            return SUM_MAX;
        end else if (e < lo) begin
            return SUM_MIN;
        end
        return e[SUM_W-1:0];
    endfunction

    // signed 64-bit add that clamps at the limits
    function automatic sum_t sat_add(input sum_t a, input sum_t b);
        logic [SUM_W:0] s;
        s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
        if (s[SUM_W] != s[SUM_W-1]) begin
            return s[SUM_W] ? SUM_MIN : SUM_MAX;
        end
        return s[SUM_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/pva_front.sv =====
// vertex intake: edge operands, bounding box, vertex count and edge products
`default_nettype none

module pva_front (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire pva_pkg::coord_t         s_x,
    input  wire pva_pkg::coord_t         s_y,
    input  wire logic                    s_last,
    input  wire pva_pkg::coord_t         test_x,
    input  wire pva_pkg::coord_t         test_y,
    input  wire logic [pva_pkg::Q_AW:0]  q_count,
    output logic                         push,
    output pva_pkg::edge_item_t          push_item
);

    localparam logic [1:0] COUNT_FULL = 2'd3;

    typedef struct packed {
        pva_pkg::opd_t a1, b1, l1a, r1a, r1b;
        pva_pkg::opd_t a2, b2, l2a, r2a, r2b;
        logic          cross1, cross2, dpos1, dpos2;
        logic          first, last, full;
        pva_pkg::box_t box;
    } ops_t;

    pva_pkg::coord_t      first_x_reg, first_y_reg;
    pva_pkg::coord_t      prev_x_reg, prev_y_reg;
    logic [1:0]           count_reg;
    pva_pkg::box_t        box_reg;

    logic                 v0_reg, v1_reg;
    ops_t                 ops_reg, ops_next;
    pva_pkg::edge_item_t  item_reg, item_next;

    logic                 accept, is_first;
    logic [1:0]           count_inc;
    logic [pva_pkg::Q_AW+1:0] inflight;
    pva_pkg::coord_t      fx, fy;
    pva_pkg::opd_t        xe, ye, pxe, pye, fxe, fye, txe, tye;
    pva_pkg::box_t        box_next;

    // every item in the two stages already owns a queue slot
    assign inflight = (pva_pkg::Q_AW+2)'(q_count) + (pva_pkg::Q_AW+2)'(v0_reg)
                    + (pva_pkg::Q_AW+2)'(v1_reg);
    assign s_tready = inflight < (pva_pkg::Q_AW+2)'(pva_pkg::Q_DEPTH);
    assign accept   = s_tvalid && s_tready;

    assign is_first  = (count_reg == 2'd0);
    assign count_inc = (count_reg == COUNT_FULL) ? COUNT_FULL : count_reg + 2'd1;

    assign fx  = is_first ? s_x : first_x_reg;
    assign fy  = is_first ? s_y : first_y_reg;
    assign xe  = pva_pkg::OPD_W'(s_x);
    assign ye  = pva_pkg::OPD_W'(s_y);
    assign pxe = pva_pkg::OPD_W'(prev_x_reg);
    assign pye = pva_pkg::OPD_W'(prev_y_reg);
    assign fxe = pva_pkg::OPD_W'(fx);
    assign fye = pva_pkg::OPD_W'(fy);
    assign txe = pva_pkg::OPD_W'(test_x);
    assign tye = pva_pkg::OPD_W'(test_y);

    always_comb begin
        if (is_first) begin
            box_next = '{min_x: s_x, min_y: s_y, max_x: s_x, max_y: s_y};
        end else begin
            box_next.min_x = (s_x < box_reg.min_x) ? s_x : box_reg.min_x;
            box_next.max_x = (s_x > box_reg.max_x) ? s_x : box_reg.max_x;
            box_next.min_y = (s_y < box_reg.min_y) ? s_y : box_reg.min_y;
            box_next.max_y = (s_y > box_reg.max_y) ? s_y : box_reg.max_y;
        end
    end

    always_comb begin
        // incoming edge prev -> cur
        ops_next.a1     = pxe + xe;
        ops_next.b1     = pye - ye;
        ops_next.l1a    = txe - xe;
        ops_next.r1a    = pxe - xe;
        ops_next.r1b    = tye - ye;
        ops_next.cross1 = !is_first && ((s_y > test_y) != (prev_y_reg > test_y));
        ops_next.dpos1  = !ops_next.b1[pva_pkg::OPD_W-1];
        // closing edge cur -> first
        ops_next.a2     = xe + fxe;
        ops_next.b2     = ye - fye;
        ops_next.l2a    = txe - fxe;
        ops_next.r2a    = xe - fxe;
        ops_next.r2b    = tye - fye;
        ops_next.cross2 = (fy > test_y) != (s_y > test_y);
        ops_next.dpos2  = !ops_next.b2[pva_pkg::OPD_W-1];
        ops_next.first  = is_first;
        ops_next.last   = s_last;
        ops_next.full   = (count_inc == COUNT_FULL);
        ops_next.box    = box_next;
    end

    always_comb begin
        item_next.term1  = ops_reg.a1 * ops_reg.b1;
        item_next.term2  = ops_reg.a2 * ops_reg.b2;
        item_next.lhs1   = ops_reg.l1a * ops_reg.b1;
        item_next.rhs1   = ops_reg.r1a * ops_reg.r1b;
        item_next.lhs2   = ops_reg.l2a * ops_reg.b2;
        item_next.rhs2   = ops_reg.r2a * ops_reg.r2b;
        item_next.cross1 = ops_reg.cross1;
        item_next.cross2 = ops_reg.cross2;
        item_next.dpos1  = ops_reg.dpos1;
        item_next.dpos2  = ops_reg.dpos2;
        item_next.first  = ops_reg.first;
        item_next.last   = ops_reg.last;
        item_next.full   = ops_reg.full;
        item_next.box    = ops_reg.box;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
            v0_reg    <= 1'b0;
            v1_reg    <= 1'b0;
        end else begin
            v0_reg <= accept;
            v1_reg <= v0_reg;
            if (accept) begin
                count_reg <= s_last ? 2'd0 : count_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            prev_x_reg <= s_x;
            prev_y_reg <= s_y;
            box_reg    <= box_next;
            if (is_first) begin
                first_x_reg <= s_x;
                first_y_reg <= s_y;
            end
        end
        ops_reg  <= ops_next;
        item_reg <= item_next;
    end

    assign push      = v1_reg;
    assign push_item = item_reg;

endmodule

`default_nettype wire

// ===== rtl/pva_queue.sv =====
// short edge queue between the intake and the accumulator
`default_nettype none

module pva_queue (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    push,
    input  wire pva_pkg::edge_item_t     push_item,
    input  wire logic                    pop,
    output logic                         pop_valid,
    output pva_pkg::edge_item_t          pop_item,
    output logic [pva_pkg::Q_AW:0]       count
);

    pva_pkg::edge_item_t        slot_reg [pva_pkg::Q_DEPTH];
    logic [pva_pkg::Q_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [pva_pkg::Q_AW:0]     count_reg, count_next;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (pva_pkg::Q_AW+1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (pva_pkg::Q_AW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + pva_pkg::Q_AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + pva_pkg::Q_AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign pop_valid = (count_reg != '0);
    assign pop_item  = slot_reg[rd_ptr_reg];
    assign count     = count_reg;

endmodule

`default_nettype wire

// ===== rtl/pva_back.sv =====
// shoelace accumulation, crossing parity and result formatting
`default_nettype none

module pva_back (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 q_valid,
    input  wire pva_pkg::edge_item_t  q_item,
    output logic                      q_pop,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [pva_pkg::AREA_W-1:0] area_value,
    output logic                      clockwise,
    output logic                      inside_res,
    output pva_pkg::box_t             box
);

    pva_pkg::sum_t  acc_reg;
    logic           par_reg;

    // closing stage: sum before the closing edge and its clamped term
    logic           close_valid_reg;
    pva_pkg::sum_t  close_sum_reg, close_term_reg;
    logic           close_par_reg, close_full_reg;
    pva_pkg::box_t  close_box_reg;

    // total stage: final signed sum
    logic           total_valid_reg;
    pva_pkg::sum_t  total_sum_reg;
    logic           total_par_reg, total_full_reg;
    pva_pkg::box_t  total_box_reg;

    // output register
    logic           out_valid_reg;
    logic [pva_pkg::AREA_W-1:0] area_reg;
    logic           cw_reg, inside_reg;
    pva_pkg::box_t  box_reg;

    pva_pkg::prod_t lhs1, rhs1, lhs2, rhs2;
    logic           tog1, tog2, par1;
    pva_pkg::sum_t  sum1, neg_sum;
    logic           out_free, total_free, close_free;
    logic           close_move, total_move;

    assign lhs1 = q_item.lhs1;
    assign rhs1 = q_item.rhs1;
    assign lhs2 = q_item.lhs2;
    assign rhs2 = q_item.rhs2;

    // crossing is exact: cross-multiplied compare, direction picks the sense
    assign tog1 = q_item.cross1 && (q_item.dpos1 ? (lhs1 < rhs1) : (lhs1 > rhs1));
    assign tog2 = q_item.cross2 && (q_item.dpos2 ? (lhs2 < rhs2) : (lhs2 > rhs2));

    assign sum1 = q_item.first ? '0
                : pva_pkg::sat_add(acc_reg, pva_pkg::sat_term(q_item.term1));
    assign par1 = q_item.first ? 1'b0 : (par_reg ^ tog1);

    assign out_free   = !out_valid_reg || m_tready;
    assign total_free = !total_valid_reg || out_free;
    assign close_free = !close_valid_reg || total_free;
    assign total_move = total_valid_reg && out_free;
    assign close_move = close_valid_reg && total_free;

    // only closing vertices occupy the result pipeline
    assign q_pop = q_valid && (!q_item.last || close_free);

    assign neg_sum = -total_sum_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg         <= '0;
            par_reg         <= 1'b0;
            close_valid_reg <= 1'b0;
            total_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (q_pop) begin
                acc_reg <= sum1;
                par_reg <= par1;
            end

            if (q_pop && q_item.last) begin
                close_valid_reg <= 1'b1;
            end else if (close_move) begin
                close_valid_reg <= 1'b0;
            end

            if (close_move) begin
                total_valid_reg <= 1'b1;
            end else if (total_move) begin
                total_valid_reg <= 1'b0;
            end

            if (total_move) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && q_item.last) begin
            close_sum_reg  <= sum1;
            close_term_reg <= pva_pkg::sat_term(q_item.term2);
            close_par_reg  <= par1 ^ tog2;
            close_full_reg <= q_item.full;
            close_box_reg  <= q_item.box;
        end
        if (close_move) begin
            total_sum_reg  <= pva_pkg::sat_add(close_sum_reg, close_term_reg);
            total_par_reg  <= close_par_reg;
            total_full_reg <= close_full_reg;
            total_box_reg  <= close_box_reg;
        end
        if (total_move) begin
            box_reg <= total_box_reg;
            if (!total_full_reg) begin
                area_reg   <= '0;
                cw_reg     <= 1'b0;
                inside_reg <= 1'b0;
            end else begin
                // most negative sum reads as the largest magnitude
                if (total_sum_reg == pva_pkg::SUM_MIN) begin
                    area_reg <= pva_pkg::SUM_MAX[pva_pkg::AREA_W-1:0];
                end else if (total_sum_reg[pva_pkg::SUM_W-1]) begin
                    area_reg <= neg_sum[pva_pkg::AREA_W-1:0];
                end else begin
                    area_reg <= total_sum_reg[pva_pkg::AREA_W-1:0];
                end
                cw_reg     <= total_sum_reg[pva_pkg::SUM_W-1];
                inside_reg <= total_par_reg;
            end
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign area_value = area_reg;
    assign clockwise  = cw_reg;
    assign inside_res = inside_reg;
    assign box        = box_reg;

endmodule

`default_nettype wire

// ===== rtl/polygon_vertex_analyzer.sv =====
// top level of the polygon vertex analyzer: stream ports, test point registers
`default_nettype none

// Usage
// - s_ channel: one request per vertex, x and y in s_tdata, s_tlast on the
//   closing vertex of a polygon. Vertices of consecutive polygons follow
//   one another directly; a request is taken every cycle while s_tready is high.
// - m_ channel: one request per polygon, sent after its closing vertex, with
//   area magnitude, clockwise flag, inside flag and bounding box.
// - cfg port: test_x (index 0) and test_y (index 1), written on any edge with
//   cfg_wr_en high; write them only while no polygon is in flight.
// Path: the closing vertex passes the intake stages, a queue slot, and the
//   close, total and output stages before m_tvalid rises.
// Throughput: one vertex per cycle while s_tready is high, set by the single
//   running-sum adder of the accumulator.
// Stall: results wait in a three-deep result pipeline; when it is full a
//   closing vertex waits at the head of the 4-entry edge queue, the queue
//   fills and s_tready drops until m_tready frees space.
// Reset (aresetn low, synchronous): both channels go empty, the vertex count
//   returns to zero and the test point reads as the origin.

module polygon_vertex_analyzer (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // input vertices
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // vertex_x [23:0], vertex_y [47:24]
    input  wire logic [pva_pkg::IN_DATA_W-1:0]     s_tdata,
    // last_vertex
    input  wire logic                              s_tlast,
    // polygon results
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // area_value [62:0], clockwise [63], inside_res [64], min_x [88:65],
    // min_y [112:89], max_x [136:113], max_y [160:137], zero padding above
    output logic [pva_pkg::OUT_DATA_W-1:0]         m_tdata,
    // configuration writes
    input  wire logic                              cfg_wr_en,
    input  wire logic [pva_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [pva_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    pva_pkg::coord_t                test_x_reg, test_y_reg;
    pva_pkg::coord_t                s_x, s_y;

    logic                           push, q_pop, q_valid;
    pva_pkg::edge_item_t            push_item, q_item;
    logic [pva_pkg::Q_AW:0]         q_count;

    logic [pva_pkg::AREA_W-1:0]     area_value;
    logic                           clockwise, inside_res;
    pva_pkg::box_t                  box;

    // test point registers, reset to the origin
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            test_x_reg <= '0;
            test_y_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                pva_pkg::REG_TEST_X: begin
                    test_x_reg <= cfg_wdata;
                end
                pva_pkg::REG_TEST_Y: begin
                    test_y_reg <= cfg_wdata;
                end
            endcase
        end
    end

    // unpack vertex coordinates
    assign s_x = s_tdata[pva_pkg::COORD_BITS-1:0];
    assign s_y = s_tdata[2*pva_pkg::COORD_BITS-1:pva_pkg::COORD_BITS];

    // intake: edge operands, box, count, products
    pva_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_x       (s_x),
        .s_y       (s_y),
        .s_last    (s_tlast),
        .test_x    (test_x_reg),
        .test_y    (test_y_reg),
        .q_count   (q_count),
        .push      (push),
        .push_item (push_item)
    );

    // decouples intake from accumulation
    pva_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_item  (q_item),
        .count     (q_count)
    );

    // accumulation and result formatting
    pva_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .area_value (area_value),
        .clockwise  (clockwise),
        .inside_res (inside_res),
        .box        (box)
    );

    // pack result fields from the lowest bit up
    assign m_tdata = {
        {(pva_pkg::OUT_DATA_W-pva_pkg::OUT_FIELD_W){1'b0}},
        box.max_y, box.max_x, box.min_y, box.min_x,
        inside_res, clockwise, area_value
    };

endmodule

`default_nettype wire
